### sv/pid_pkg.sv
`default_nettype none
package pid_pkg;

	localparam int CAPACITY = 32;
	localparam int WORD_W   = 32;
	localparam int POS_W    = 5;
	localparam int LEN_W    = 6;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_DELETE = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DELETE
	} cell_op_t;

	// Broadcast to every cell in the row
	typedef struct packed {
		cell_op_t                op;
		logic [CMP_W-1:0]        pos;
		logic [WORD_W-1:0]       value;
	} cell_ctrl_t;

endpackage
`default_nettype wire

### sv/pid_cell.sv
`default_nettype none
module pid_cell (
	input  wire logic                       clk,
	input  wire logic [pid_pkg::CMP_W-1:0]  idx,
	input  wire pid_pkg::cell_ctrl_t        ctrl,
	input  wire logic [pid_pkg::WORD_W-1:0] prev_word,
	input  wire logic [pid_pkg::WORD_W-1:0] next_word,
	output logic      [pid_pkg::WORD_W-1:0] word
);
	import pid_pkg::*;

	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] word_nxt;

	always_comb begin
		word_nxt = word_q;
		unique case (ctrl.op)
			CELL_INSERT: begin
				// take the lower neighbour above the slot, the new word at the slot
				if (idx > ctrl.pos) begin
					word_nxt = prev_word;
				end else if (idx == ctrl.pos) begin
					word_nxt = ctrl.value;
				end
			end
			CELL_DELETE: begin
				if (idx >= ctrl.pos) begin
					word_nxt = next_word;
				end
			end
			default: begin
				word_nxt = word_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_nxt;
	end

	assign word = word_q;

endmodule
`default_nettype wire

### sv/positional_insert_delete_array.sv
// The result of a transaction is presented in the cycle after it is accepted.
// Throughput: one transaction per cycle while not stalled; every cell of the row
//   shifts in parallel, so no action takes longer for a far position.
// A new transaction is taken while the output register drains in the same cycle.
// Reset (arst_n low, asynchronous): entry count and output valid cleared;
//   stored words are left undefined and never read before being written.
`default_nettype none
module positional_insert_delete_array (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [1:0]                        action,
	input  wire logic [pid_pkg::POS_W-1:0]         position,
	input  wire logic signed [pid_pkg::WORD_W-1:0] value,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [pid_pkg::WORD_W-1:0]      data_out,
	output logic [1:0]                             status,
	output logic [pid_pkg::LEN_W-1:0]              length
);
	import pid_pkg::*;

	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] data_q;
	logic [1:0]        status_q;
	logic [LEN_W-1:0]  length_q;

	logic              accept;
	logic [CMP_W-1:0]  pos_c;
	logic [CMP_W-1:0]  cnt_c;
	logic              is_full;
	logic              is_empty;
	logic [1:0]        status_nxt;
	logic [WORD_W-1:0] data_nxt;
	logic [CNT_W-1:0]  count_nxt;
	logic [WORD_W-1:0] rd_word;
	cell_ctrl_t        cell_ctrl;
	logic [WORD_W-1:0] cell_word [CAPACITY];

	// Hold the input while a result is waiting and the far side stalls it
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	assign pos_c    = CMP_W'(position);
	assign cnt_c    = CMP_W'(count_q);
	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	// Select the word at the requested position; each tap is gated by its own index
	always_comb begin
		rd_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (CMP_W'(i) == pos_c) begin
				rd_word = rd_word | cell_word[i];
			end
		end
	end

	// Decide the outcome of the transaction and the command for the cell row.
	// A refused request leaves the cells holding and the count unchanged.
	always_comb begin
		status_nxt      = ST_OK;
		data_nxt        = '0;
		count_nxt       = count_q;
		cell_ctrl.op    = CELL_HOLD;
		cell_ctrl.pos   = pos_c;
		cell_ctrl.value = value;
		unique case (action)
			ACT_INSERT: begin
				if (is_full) begin
					status_nxt = ST_FULL;
				end else if (pos_c > cnt_c) begin
					status_nxt = ST_RANGE;
				end else begin
					count_nxt = count_q + CNT_W'(1);
					if (accept) begin
						cell_ctrl.op = CELL_INSERT;
					end
				end
			end
			ACT_DELETE, ACT_READ: begin
				if (is_empty) begin
					status_nxt = ST_EMPTY;
				end else if (pos_c >= cnt_c) begin
					status_nxt = ST_RANGE;
				end else begin
					data_nxt = rd_word;
					if (action == ACT_DELETE) begin
						count_nxt = count_q - CNT_W'(1);
						if (accept) begin
							cell_ctrl.op = CELL_DELETE;
						end
					end
				end
			end
			default: begin
				// unused action code: answer ok, change nothing
				status_nxt = ST_OK;
			end
		endcase
	end

	// Row of storage cells; each hands its word to a neighbour on a shift
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_W-1:0] prev_w;
		logic [WORD_W-1:0] next_w;

		if (i == 0) begin : g_first
			assign prev_w = cell_ctrl.value;
		end else begin : g_prev
			assign prev_w = cell_word[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_w = cell_word[i];
		end else begin : g_next
			assign next_w = cell_word[i+1];
		end

		pid_cell u_cell (
			.clk       (clk),
			.idx       (CMP_W'(i)),
			.ctrl      (cell_ctrl),
			.prev_word (prev_w),
			.next_word (next_w),
			.word      (cell_word[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				// drop the result once taken
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; advance only on a new transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q   <= data_nxt;
			status_q <= status_nxt;
			length_q <= LEN_W'(count_nxt);
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_q;
	assign status    = status_q;
	assign length    = length_q;

endmodule
`default_nettype wire

### sv/pid_checker.sv
`default_nettype none
module pid_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire logic                              in_stall,
	input  wire logic [1:0]                        action,
	input  wire logic [pid_pkg::POS_W-1:0]         position,
	input  wire logic signed [pid_pkg::WORD_W-1:0] value,
	input  wire logic                              out_valid,
	input  wire logic                              out_stall,
	input  wire logic signed [pid_pkg::WORD_W-1:0] data_out,
	input  wire logic [1:0]                        status,
	input  wire logic [pid_pkg::LEN_W-1:0]         length
);
	import pid_pkg::*;

	// A stalled result stays presented
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// Input is only held back by a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> length <= LEN_W'(CAPACITY))
		else $error("length beyond capacity");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> length == LEN_W'(CAPACITY) && data_out == '0)
		else $error("full reported below capacity");

	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> length == '0 && data_out == '0)
		else $error("empty reported with entries stored");

endmodule

bind positional_insert_delete_array pid_checker u_pid_checker (.*);
`default_nettype wire
